### rtl/fpfa_pkg.sv
package fpfa_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);

    // Fixed field widths of the ports.
    localparam int REQ_W  = 16;
    localparam int BIU_W  = 5;
    localparam int POL_W  = 2;
    localparam int MODE_W = 2;
    localparam int SUM_W  = 20;
    localparam int CFG_W  = 1;

    // Derived widths for compares and sums.
    localparam int CMP_W  = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
    localparam int WSUM_W = SIZE_BITS + IDX_W;
    localparam int WSAT_W = (WSUM_W > SUM_W) ? WSUM_W : SUM_W;
    localparam int ACC_W  = ((CMP_W > SUM_W) ? CMP_W : SUM_W) + 1;
    localparam int ACT_W  = (IDX_W + 1 > BIU_W) ? IDX_W + 1 : BIU_W;

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(16);

    // Allocation policy codes; the unused code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_W-1:0] CFG_BIU    = 1'b1;

    // Record that walks down the row of cells during a scan.
    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     pick_idx;
        logic [SIZE_BITS-1:0] pick_size;
        logic [WSUM_W-1:0]    total;
        logic [WSUM_W-1:0]    ext;
    } scan_t;

    // Broadcast update command from the controller to every cell.
    typedef struct packed {
        logic                 load_en;
        logic                 clear_en;
        logic                 take_en;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } cell_ctl_t;

    function automatic logic [SUM_W-1:0] sat_wide(input logic [WSUM_W-1:0] v);
        logic [WSAT_W-1:0] w;
        w = WSAT_W'(v);
        return (w > WSAT_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(w);
    endfunction

    function automatic logic [SUM_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
        return (v > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(v);
    endfunction

endpackage

### rtl/fpfa_cell.sv
module fpfa_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [fpfa_pkg::IDX_W-1:0] cell_idx,
    input  fpfa_pkg::cell_ctl_t      ctl,
    input  logic [fpfa_pkg::REQ_W-1:0] want,
    input  logic [fpfa_pkg::POL_W-1:0] policy,
    input  logic [fpfa_pkg::BIU_W-1:0] biu,
    input  fpfa_pkg::scan_t          scan_in,
    output fpfa_pkg::scan_t          scan_out
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] size_reg;
    logic                 taken_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    logic                 active;
    logic                 fits;
    logic                 better;
    logic                 take;

    // Each cell folds its own block into the record and passes it on.
    always_comb
    begin
        active = ACT_W'(cell_idx) < ACT_W'(biu);
        fits   = active && !taken_reg && (CMP_W'(size_reg) >= CMP_W'(want));
        better = ((policy == POL_BEST) && (size_reg < scan_in.pick_size)) ||
                 ((policy == POL_WORST) && (size_reg > scan_in.pick_size));
        take   = fits && (!scan_in.found || better);

        scan_next = scan_in;
        if (take)
        begin
            scan_next.found     = 1'b1;
            scan_next.pick_idx  = cell_idx;
            scan_next.pick_size = size_reg;
        end
        if (active)
        begin
            scan_next.total = scan_in.total + WSUM_W'(size_reg);
            if (!taken_reg)
            begin
                scan_next.ext = scan_in.ext + WSUM_W'(size_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= '0;
            taken_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load_en && (ctl.idx == cell_idx))
            begin
                size_reg <= ctl.size;
            end
            if (ctl.clear_en)
            begin
                taken_reg <= 1'b0;
            end
            else if (ctl.take_en && (ctl.idx == cell_idx))
            begin
                taken_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule

### rtl/fixed_partition_fit_allocator.sv
// Fixed-partition allocator over a table of NUM_BLOCKS block sizes. An item is
// taken when start is high and busy is low; its mode loads one block size,
// starts a new run (frees every block and clears the used and internal totals),
// or requests a block under the first, best or worst fit policy, and the unused
// mode code changes nothing. Every item yields exactly one result beat, shown
// for a single cycle with done high; the receiver cannot stall it, so it must
// capture the beat in that cycle. Busy rises once an item is accepted and stays
// high until the cycle that shows its result beat, in which the next item may
// be started. The scan record moves one cell per cycle through the row of
// cells, then a settle step fixes the grant and the totals, a report step
// forms the wasted-memory sum, and the block is idle again in the cycle that
// shows the result beat. Configuration registers (policy, blocks_in_use) are
// written through cfg_we; the user must do so only while busy is low and no
// result is pending, as the block itself does not enforce it.
module fixed_partition_fit_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fpfa_pkg::MODE_W-1:0]   mode,
    input  logic [fpfa_pkg::IDX_W-1:0]    block_index,
    input  logic [fpfa_pkg::REQ_W-1:0]    size,
    output logic                          done,
    output logic                          granted,
    output logic [fpfa_pkg::IDX_W-1:0]    granted_block,
    output logic [fpfa_pkg::SUM_W-1:0]    total_memory,
    output logic [fpfa_pkg::SUM_W-1:0]    used_memory,
    output logic [fpfa_pkg::SUM_W-1:0]    internal_frag,
    output logic [fpfa_pkg::SUM_W-1:0]    external_frag,
    output logic [fpfa_pkg::SUM_W-1:0]    wasted_memory,
    input  logic                          cfg_we,
    input  logic [fpfa_pkg::CFG_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::BIU_W-1:0]    cfg_wdata
);
    import fpfa_pkg::*;

    // One-hot controller states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SETTLE = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [POL_W-1:0]     policy_reg;
    logic [BIU_W-1:0]     biu_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [REQ_W-1:0]     want_reg;
    logic [SUM_W-1:0]     used_sum_reg;
    logic [SUM_W-1:0]     internal_sum_reg;
    logic                 granted_reg;
    logic [IDX_W-1:0]     gblock_reg;
    logic [SUM_W-1:0]     total_reg;
    logic [SUM_W-1:0]     ext_reg;
    logic [SUM_W-1:0]     wasted_reg;
    logic                 done_reg;

    logic                 accept;
    logic                 grant;
    logic [WSUM_W-1:0]    ext_adj;
    logic [CMP_W-1:0]     slack;
    cell_ctl_t            ctl;
    scan_t                chain [NUM_BLOCKS+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // The record entering the first cell starts empty: nothing picked, no sums.
    assign chain[0] = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_cell
        fpfa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .ctl      (ctl),
            .want     (want_reg),
            .policy   (policy_reg),
            .biu      (biu_reg),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    // The record leaving the last cell holds the pick and the sums taken
    // before the grant; the granted block leaves the free total here.
    assign grant   = (mode_reg == MODE_REQ) && chain[NUM_BLOCKS].found;
    assign ext_adj = chain[NUM_BLOCKS].ext -
                     (grant ? WSUM_W'(chain[NUM_BLOCKS].pick_size) : '0);
    assign slack   = CMP_W'(chain[NUM_BLOCKS].pick_size) - CMP_W'(want_reg);

    // Loads and run clears reach the cells at acceptance, so the scan that
    // follows already sees them; a grant marks its block in the settle cycle.
    always_comb
    begin
        ctl = '0;
        if (accept)
        begin
            ctl.load_en  = (mode == MODE_LOAD);
            ctl.clear_en = (mode == MODE_RUN);
            ctl.idx      = block_index;
            ctl.size     = SIZE_BITS'(size);
        end
        else if (state_reg == ST_SETTLE)
        begin
            ctl.take_en = grant;
            ctl.idx     = chain[NUM_BLOCKS].pick_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            biu_reg    <= BIU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_wdata[POL_W-1:0];
                CFG_BIU:    biu_reg    <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            done_reg         <= 1'b0;
            mode_reg         <= MODE_LOAD;
            want_reg         <= '0;
            used_sum_reg     <= '0;
            internal_sum_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        mode_reg  <= mode;
                        want_reg  <= size;
                        state_reg <= ST_SCAN;
                        if (mode == MODE_RUN)
                        begin
                            used_sum_reg     <= '0;
                            internal_sum_reg <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // The last cell captures the record at the edge that ends
                    // the cycle where the count reaches the final index.
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(NUM_BLOCKS - 1))
                    begin
                        state_reg <= ST_SETTLE;
                    end
                end
                ST_SETTLE:
                begin
                    if (grant)
                    begin
                        used_sum_reg     <= sat_acc(ACC_W'(used_sum_reg) + ACC_W'(want_reg));
                        internal_sum_reg <= sat_acc(ACC_W'(internal_sum_reg) + ACC_W'(slack));
                    end
                    state_reg <= ST_REPORT;
                end
                ST_REPORT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload registers; done qualifies them.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETTLE)
        begin
            granted_reg <= grant;
            gblock_reg  <= grant ? chain[NUM_BLOCKS].pick_idx : '0;
            total_reg   <= sat_wide(chain[NUM_BLOCKS].total);
            ext_reg     <= sat_wide(ext_adj);
        end
        if (state_reg == ST_REPORT)
        begin
            wasted_reg <= sat_acc(ACC_W'(internal_sum_reg) + ACC_W'(ext_reg));
        end
    end

    assign done          = done_reg;
    assign granted       = granted_reg;
    assign granted_block = gblock_reg;
    assign total_memory  = total_reg;
    assign used_memory   = used_sum_reg;
    assign internal_frag = internal_sum_reg;
    assign external_frag = ext_reg;
    assign wasted_memory = wasted_reg;

`ifndef SYNTHESIS
    // A result beat only follows the report cycle.
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_REPORT))
        else $error("result beat without a report cycle");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not make the block busy");

    // A denied item reports block zero.
    a_denied_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (granted_block == '0))
        else $error("denied item reports a nonzero block");

    // Wasted memory never falls below the external fragmentation.
    a_wasted_covers_ext: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wasted_memory >= external_frag))
        else $error("wasted memory below external fragmentation");
`endif

endmodule

### bench/fixed_partition_fit_allocator_tb.sv
module fixed_partition_fit_allocator_tb;
    import fpfa_pkg::*;

    // The package names three of the four mode and policy codes. The fourth
    // value of each field is legal on the wire, so it gets a name here.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic [POL_W-1:0]  POL_SPARE = 2'd3;

    // Longest quiet stretch of a correct run is a sender gap plus register
    // writes, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles watched after the last result for stray result beats.
    localparam int DRAIN_CYCLES = NUM_BLOCKS + 8;

    // One result beat as the block should report it.
    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] blk;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] used;
        logic [SUM_W-1:0] intf;
        logic [SUM_W-1:0] extf;
        logic [SUM_W-1:0] waste;
    } frag_report_t;

    // Every input of the block has a known value from time zero.
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic [MODE_W-1:0] mode        = MODE_LOAD;
    logic [IDX_W-1:0]  block_index = '0;
    logic [REQ_W-1:0]  size        = '0;
    logic              cfg_we      = 1'b0;
    logic [CFG_W-1:0]  cfg_index   = CFG_POLICY;
    logic [BIU_W-1:0]  cfg_wdata   = '0;

    logic              busy;
    logic              done;
    logic              granted;
    logic [IDX_W-1:0]  granted_block;
    logic [SUM_W-1:0]  total_memory;
    logic [SUM_W-1:0]  used_memory;
    logic [SUM_W-1:0]  internal_frag;
    logic [SUM_W-1:0]  external_frag;
    logic [SUM_W-1:0]  wasted_memory;

    // Shadow copy of the partition table, the run totals and the registers.
    logic [SIZE_BITS-1:0] part_size [NUM_BLOCKS];
    logic                 part_taken [NUM_BLOCKS];
    logic [SUM_W-1:0]     run_used;
    logic [SUM_W-1:0]     run_internal;
    logic [POL_W-1:0]     fit_policy;
    logic [BIU_W-1:0]     part_count;

    // Reports predicted at acceptance, oldest first.
    frag_report_t pending_reports [$];
    int errors = 0;
    // Chance, in percent, that the sender leaves a gap before an item.
    int send_idle_pct = 0;

    fixed_partition_fit_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .block_index   (block_index),
        .size          (size),
        .done          (done),
        .granted       (granted),
        .granted_block (granted_block),
        .total_memory  (total_memory),
        .used_memory   (used_memory),
        .internal_frag (internal_frag),
        .external_frag (external_frag),
        .wasted_memory (wasted_memory),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Allocation model
    // ------------------------------------------------------------------

    // All sums and totals clip at the top of the 20-bit range.
    function automatic logic [SUM_W-1:0] sum_clip(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > 33'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Blocks taking part: counts beyond the table act as the full table.
    function automatic int active_parts();
        return (part_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(part_count);
    endfunction

    // Chooses a free block that holds the request, or returns -1. Ties go to
    // the lowest index, and the spare policy code falls back to first fit.
    function automatic int fit_pick(input logic [REQ_W-1:0] want);
        int pick;
        int n;
        pick = -1;
        n = active_parts();
        for (int j = 0; j < n; j++)
        begin
            if (part_taken[j] || part_size[j] < want)
                continue;
            if (pick < 0)
            begin
                pick = j;
                if (fit_policy != POL_BEST && fit_policy != POL_WORST)
                    break;
            end
            else if (fit_policy == POL_BEST && part_size[j] < part_size[pick])
                pick = j;
            else if (fit_policy == POL_WORST && part_size[j] > part_size[pick])
                pick = j;
        end
        return pick;
    endfunction

    task automatic reset_model();
        foreach (part_size[j])
        begin
            part_size[j] = '0;
            part_taken[j] = 1'b0;
        end
        run_used = '0;
        run_internal = '0;
        fit_policy = POL_FIRST;
        part_count = BIU_RESET;
    endtask

    // Applies one accepted item to the shadow state and queues its report.
    task automatic predict_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                                input logic [REQ_W-1:0] sz);
        frag_report_t r;
        int p;
        int n;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] extf;
        r = '0;
        total = '0;
        extf = '0;
        case (m)
            MODE_LOAD:
            begin
                if (idx < NUM_BLOCKS)
                    part_size[idx] = SIZE_BITS'(sz);
            end
            MODE_RUN:
            begin
                foreach (part_taken[j])
                    part_taken[j] = 1'b0;
                run_used = '0;
                run_internal = '0;
            end
            MODE_REQ:
            begin
                p = fit_pick(sz);
                if (p >= 0)
                begin
                    part_taken[p] = 1'b1;
                    run_used = sum_clip(32'(run_used), 32'(sz));
                    run_internal = sum_clip(32'(run_internal),
                                            32'(part_size[p]) - 32'(sz));
                    r.granted = 1'b1;
                    r.blk = IDX_W'(p);
                end
            end
            default:
            begin
            end
        endcase
        n = active_parts();
        for (int j = 0; j < n; j++)
        begin
            total = sum_clip(32'(total), 32'(part_size[j]));
            if (!part_taken[j])
                extf = sum_clip(32'(extf), 32'(part_size[j]));
        end
        r.total = total;
        r.used = run_used;
        r.intf = run_internal;
        r.extf = extf;
        r.waste = sum_clip(32'(run_internal), 32'(extf));
        pending_reports.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one item beat. Start is lowered at the edge that accepts and raised
    // again no sooner than the rising edge after it, so it never gets two
    // assignments in one time step. The optional gap lands the raise anywhere
    // within or beyond an item. Acceptance is decided from values seen at the
    // falling edge, where everything driven or produced at the last rising edge
    // has settled.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                             input logic [REQ_W-1:0] sz);
        @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(40, 1)) @(posedge clk);
        start <= 1'b1;
        mode <= m;
        block_index <= idx;
        size <= sz;
        do @(negedge clk); while (busy);
        @(posedge clk);
        start <= 1'b0;
        predict_item(m, idx, sz);
    endtask

    // Register writes happen only with nothing in flight. The queue shrinks
    // only at falling edges, so reading it at a rising edge is race free, and
    // with start low and every result out the block is idle.
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [BIU_W-1:0] val);
        do @(posedge clk); while (pending_reports.size() != 0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POLICY)
            fit_policy = val[POL_W-1:0];
        else
            part_count = val;
    endtask

    // Block sizes mix the ends of the range with small values, so that
    // requests often fit and the fit policies have real choices to make.
    function automatic logic [REQ_W-1:0] rand_size();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return REQ_W'($urandom_range(255));
            4, 5:    return REQ_W'($urandom_range(4095));
            default: return REQ_W'($urandom_range(65535));
        endcase
    endfunction

    // Half of the requests aim at a block in the table: its exact size or a
    // little less, which brings exact fits and near misses.
    function automatic logic [REQ_W-1:0] req_size();
        logic [SIZE_BITS-1:0] s;
        int k;
        if ($urandom_range(1))
        begin
            s = part_size[$urandom_range(NUM_BLOCKS - 1)];
            k = $urandom_range(3);
            return (s > k) ? REQ_W'(s - k) : '0;
        end
        return rand_size();
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [SUM_W-1:0] exp_v,
                                 input logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // A result beat lasts one cycle and cannot be held off, so it is captured
    // at the falling edge inside that cycle.
    always @(negedge clk)
    begin : check_results
        frag_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no item outstanding", $time);
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("granted", SUM_W'(want.granted), SUM_W'(granted));
                compare_field("granted_block", SUM_W'(want.blk), SUM_W'(granted_block));
                compare_field("total_memory", want.total, total_memory);
                compare_field("used_memory", want.used, used_memory);
                compare_field("internal_frag", want.intf, internal_frag);
                compare_field("external_frag", want.extf, external_frag);
                compare_field("wasted_memory", want.waste, wasted_memory);
            end
        end
    end

    // Ends the run if neither an item nor a result moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("[fixed_partition_fit_allocator] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs under the reset settings (first fit, sixteen blocks) on an empty
    // table: zero requests on zero blocks, denials, the ends of the size
    // range, the unused mode, a reload of a taken block and a new run.
    task automatic test_directed_edges();
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd1);
        send_item(MODE_NONE, 4'd15, 16'hFFFF);
        send_item(MODE_RUN, 4'd15, 16'hFFFF);
        send_item(MODE_LOAD, 4'd15, 16'hFFFF);
        send_item(MODE_LOAD, 4'd0, 16'd1);
        send_item(MODE_LOAD, 4'd7, 16'h5555);
        send_item(MODE_LOAD, 4'd8, 16'hAAAA);
        send_item(MODE_REQ, 4'd0, 16'hFFFF);
        send_item(MODE_REQ, 4'd0, 16'hFFFF);
        send_item(MODE_REQ, 4'd0, 16'd1);
        send_item(MODE_REQ, 4'd0, 16'd2);
        // Shrinking a block that is already taken leaves the used and internal sums alone.
        send_item(MODE_LOAD, 4'd15, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_NONE, 4'd0, 16'd0);
        send_item(MODE_RUN, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd15, 16'hAAAA);
        send_item(MODE_REQ, 4'd0, 16'd0);
    endtask

    // Four blocks with a duplicate size, asked for twice at that size and once
    // smaller, so first, best and worst fit and the tie rule give three orders.
    task automatic test_fit_policies();
        logic [POL_W-1:0] order [4];
        order = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE};
        write_reg(CFG_BIU, 5'd4);
        send_item(MODE_LOAD, 4'd0, 16'd300);
        send_item(MODE_LOAD, 4'd1, 16'd100);
        send_item(MODE_LOAD, 4'd2, 16'd500);
        send_item(MODE_LOAD, 4'd3, 16'd100);
        foreach (order[p])
        begin
            write_reg(CFG_POLICY, BIU_W'(order[p]));
            send_item(MODE_RUN, 4'd0, 16'd0);
            send_item(MODE_REQ, 4'd0, 16'd100);
            send_item(MODE_REQ, 4'd0, 16'd100);
            send_item(MODE_REQ, 4'd0, 16'd50);
        end
    endtask

    // Block counts of zero, one and above the table, and taken marks that
    // survive while their blocks are left out of the count.
    task automatic test_block_count();
        write_reg(CFG_POLICY, BIU_W'(POL_FIRST));
        write_reg(CFG_BIU, 5'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_NONE, 4'd9, 16'd7);
        write_reg(CFG_BIU, 5'd1);
        send_item(MODE_RUN, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
        write_reg(CFG_BIU, 5'd17);
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
        write_reg(CFG_BIU, 5'd31);
        send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_RUN, 4'd0, 16'd0);
        write_reg(CFG_BIU, 5'd16);
    endtask

    // Fills every block with the largest size and grants each with a zero
    // request, which drives total and internal fragmentation to their
    // highest reachable values just under the clip point.
    task automatic test_full_table();
        write_reg(CFG_POLICY, BIU_W'(POL_WORST));
        for (int j = 0; j < NUM_BLOCKS; j++)
            send_item(MODE_LOAD, IDX_W'(j), 16'hFFFF);
        send_item(MODE_RUN, 4'd0, 16'd0);
        for (int j = 0; j < NUM_BLOCKS; j++)
            send_item(MODE_REQ, 4'd0, 16'd0);
        send_item(MODE_REQ, 4'd0, 16'd0);
    endtask

    // Random traffic under changing settings. Each setting starts a fresh run
    // and then mixes mostly requests with loads, some new runs and a few
    // beats of the unused mode. Block counts favor the extremes.
    task automatic test_random_traffic(input int settings, input int per_setting);
        logic [BIU_W-1:0] count;
        int roll;
        for (int s = 0; s < settings; s++)
        begin
            case ($urandom_range(9))
                0:       count = 5'd0;
                1:       count = 5'd1;
                2:       count = 5'd16;
                3:       count = 5'd17;
                4:       count = 5'd31;
                default: count = BIU_W'($urandom_range(16, 2));
            endcase
            write_reg(CFG_POLICY, BIU_W'($urandom_range(3)));
            write_reg(CFG_BIU, count);
            send_item(MODE_RUN, IDX_W'($urandom_range(15)), rand_size());
            for (int i = 0; i < per_setting; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                    send_item(MODE_RUN, IDX_W'($urandom_range(15)), rand_size());
                else if (roll < 26)
                    send_item(MODE_LOAD, IDX_W'($urandom_range(15)), rand_size());
                else if (roll < 31)
                    send_item(MODE_NONE, IDX_W'($urandom_range(15)), rand_size());
                else
                    send_item(MODE_REQ, IDX_W'($urandom_range(15)), req_size());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Light sender gaps for the directed tests and the first random phase.
        send_idle_pct = 14;
        test_directed_edges();
        test_fit_policies();
        test_block_count();
        test_full_table();
        test_random_traffic(12, 46);

        // Heavy sender gaps.
        send_idle_pct = 78;
        test_random_traffic(12, 46);

        // Back to back items.
        send_idle_pct = 0;
        test_random_traffic(12, 46);

        // Wait out the remaining results, then watch for stray result beats.
        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_reports.size() == 0)
            $display("[fixed_partition_fit_allocator] OK");
        else
            $display("[fixed_partition_fit_allocator] ERROR");
        $finish;
    end

endmodule
